// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define ASSERT_PROP(name, prop, msg)
`define ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== sv/cnlb_pkg.sv =====
// ----------------------------------------------------------------------------
// cnlb_pkg
// shared types and constants of the cutoff neighbor list builder
// ----------------------------------------------------------------------------
`default_nettype none

package cnlb_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned BOX_W      = 31;
  localparam int unsigned CUTOFF_W   = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MAX_ATOMS_DEFAULT = 64;

  // 50.0 in q16.16
  localparam logic [BOX_W-1:0]    BOX_RESET    = 31'd3276800;
  // 196.0 in q32.32
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 64'd841813590016;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQUARED = 2'd1;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } coord_t;

  // pair unit status back to the row sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } pair_status_t;

endpackage

`default_nettype wire

// ===== sv/cutoff_neighbor_list_builder.sv =====
// ----------------------------------------------------------------------------
// cutoff_neighbor_list_builder
// loads atom positions, then builds one neighbor bitmap per atom using a
// minimum-image cutoff test carried out by a shared pair unit
// ----------------------------------------------------------------------------
//
//  channel   direction  request contents (low bits first)
//  s_axis    in         tdata: pos_x, pos_y, pos_z; tlast: final_atom
//  m_axis    out        tdata: atom_index, neighbor_mask; tlast: end_of_run;
//                       tuser: overflowed
//  cfg       in         cfg_index_i selects box_length (0) or cutoff_squared (1)
//
//  loading takes one request per cycle; the request with tlast starts the search
//  search: the pair unit takes 6 steps per axis and a compare per ordered pair,
//  after a position read; s_axis_tready_o is low during the search
//  one result per atom leaves through an output register; a stalled consumer
//  holds the search at the end of the next row
//  reset sets state, counters, flags and config; position memory has no reset value
//
`default_nettype none

module cutoff_neighbor_list_builder #(
  parameter int unsigned MAX_ATOMS = cnlb_pkg::MAX_ATOMS_DEFAULT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  wire logic [3*cnlb_pkg::COORD_W-1:0]       s_axis_tdata_i,
  input  wire logic                                 s_axis_tlast_i,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // atom_index [5:0], neighbor_mask [69:6], zero fill [71:70]
  output logic [71:0]                               m_axis_tdata_o,
  // overflowed [0]
  output logic                                      m_axis_tuser_o,
  output logic                                      m_axis_tlast_o,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [cnlb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [cnlb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_ATOMS);      // atom index
  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);  // atom count

  typedef enum logic [6:0] {
    ST_LOAD = 7'b000_0001,  // taking positions
    ST_RDI  = 7'b000_0010,  // read row atom
    ST_LATI = 7'b000_0100,  // latch row atom, clear row mask
    ST_RDJ  = 7'b000_1000,  // read column atom or skip own index
    ST_JST  = 7'b001_0000,  // start the pair unit
    ST_PAIR = 7'b010_0000,  // wait for the pair result
    ST_EMIT = 7'b100_0000   // hand the row to the output register
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [IW-1:0] last_q, last_d;
  logic [IW-1:0] row_q, row_d;
  logic [IW-1:0] col_q, col_d;
  logic [cnlb_pkg::MASK_W-1:0] mask_q, mask_d;

  // configuration
  logic [cnlb_pkg::BOX_W-1:0]    box_q, box_d;
  logic [cnlb_pkg::CUTOFF_W-1:0] cutoff_q, cutoff_d;

  // position memory, registered read port
  cnlb_pkg::coord_t coord_mem [MAX_ATOMS];
  cnlb_pkg::coord_t rd_q;
  cnlb_pkg::coord_t pi_q, pi_d;
  cnlb_pkg::coord_t wr_coord;
  logic             wr_en;
  logic [IW-1:0]    rd_addr;
  logic             rd_en;

  // output register
  logic                        m_valid_q, m_valid_d;
  logic [cnlb_pkg::IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [cnlb_pkg::MASK_W-1:0] out_mask_q, out_mask_d;
  logic                        out_last_q, out_last_d;
  logic                        out_ovf_q, out_ovf_d;

  logic s_fire, full, out_free, pair_start;
  logic [CW-1:0] cnt_inc;
  cnlb_pkg::pair_status_t pair_st;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (cnt_q == CW'(MAX_ATOMS));
  assign cnt_inc         = cnt_q + {{(CW-1){1'b0}}, 1'b1};
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign pair_start      = (state_q == ST_JST);

  assign wr_coord.x = s_axis_tdata_i[31:0];
  assign wr_coord.y = s_axis_tdata_i[63:32];
  assign wr_coord.z = s_axis_tdata_i[95:64];
  assign wr_en      = s_fire && !full;

  assign rd_addr = (state_q == ST_RDI) ? row_q : col_q;
  assign rd_en   = (state_q == ST_RDI) || ((state_q == ST_RDJ) && (col_q != row_q));

  // configuration port, always ready; unknown indexes are ignored
  assign cfg_ready_o = 1'b1;
  always_comb begin
    box_d    = box_q;
    cutoff_d = cutoff_q;
    if (cfg_valid_i) begin
      priority if (cfg_index_i == cnlb_pkg::REG_BOX_LENGTH) begin
        box_d = cfg_data_i[cnlb_pkg::BOX_W-1:0];
      end else if (cfg_index_i == cnlb_pkg::REG_CUTOFF_SQUARED) begin
        cutoff_d = cfg_data_i;
      end else begin
        box_d = box_q;
      end
    end
  end

  // shared pair test; row and column positions stay put while it runs
  cnlb_pair_unit u_pair (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pair_start),
    .coord_i_i (pi_q),
    .coord_j_i (rd_q),
    .box_i     (box_q),
    .cutoff_i  (cutoff_q),
    .status_o  (pair_st)
  );

  // row sequencer: every row tests all other atoms, so each row mask is complete
  // without a second table of masks; the symmetric test runs for both orders
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    last_d     = last_q;
    row_d      = row_q;
    col_d      = col_q;
    mask_d     = mask_q;
    pi_d       = pi_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    out_idx_d  = out_idx_q;
    out_mask_d = out_mask_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;

    unique case (state_q)
      ST_LOAD: begin
        if (s_fire) begin
          if (full) drop_d = 1'b1;
          else      cnt_d  = cnt_inc;
          if (s_axis_tlast_i) begin
            // at least one atom is stored whenever the search starts
            last_d  = full ? IW'(cnt_q - {{(CW-1){1'b0}}, 1'b1}) : IW'(cnt_q);
            row_d   = {IW{1'b0}};
            state_d = ST_RDI;
          end
        end
      end
      ST_RDI: begin
        state_d = ST_LATI;
      end
      ST_LATI: begin
        pi_d    = rd_q;
        col_d   = {IW{1'b0}};
        mask_d  = {cnlb_pkg::MASK_W{1'b0}};
        state_d = ST_RDJ;
      end
      ST_RDJ: begin
        if (col_q == row_q) begin
          // own index, no test
          if (col_q == last_q) state_d = ST_EMIT;
          else                 col_d   = col_q + {{(IW-1){1'b0}}, 1'b1};
        end else begin
          state_d = ST_JST;
        end
      end
      ST_JST: begin
        state_d = ST_PAIR;
      end
      ST_PAIR: begin
        if (pair_st.done) begin
          if (pair_st.hit) mask_d[cnlb_pkg::IDX_W'(col_q)] = 1'b1;
          if (col_q == last_q) begin
            state_d = ST_EMIT;
          end else begin
            col_d   = col_q + {{(IW-1){1'b0}}, 1'b1};
            state_d = ST_RDJ;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          out_idx_d  = cnlb_pkg::IDX_W'(row_q);
          out_mask_d = mask_q;
          out_last_d = (row_q == last_q);
          out_ovf_d  = drop_q;
          if (row_q == last_q) begin
            cnt_d   = {CW{1'b0}};
            drop_d  = 1'b0;
            state_d = ST_LOAD;
          end else begin
            row_d   = row_q + {{(IW-1){1'b0}}, 1'b1};
            state_d = ST_RDI;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_mask_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= {CW{1'b0}};
      drop_q    <= 1'b0;
      last_q    <= {IW{1'b0}};
      row_q     <= {IW{1'b0}};
      col_q     <= {IW{1'b0}};
      m_valid_q <= 1'b0;
      box_q     <= cnlb_pkg::BOX_RESET;
      cutoff_q  <= cnlb_pkg::CUTOFF_RESET;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      last_q    <= last_d;
      row_q     <= row_d;
      col_q     <= col_d;
      m_valid_q <= m_valid_d;
      box_q     <= box_d;
      cutoff_q  <= cutoff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q     <= mask_d;
    pi_q       <= pi_d;
    out_idx_q  <= out_idx_d;
    out_mask_q <= out_mask_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  // position memory
  always_ff @(posedge clk_i) begin
    if (wr_en) coord_mem[cnt_q[IW-1:0]] <= wr_coord;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= coord_mem[rd_addr];
  end

  `include "assert_macros.svh"

  `ASSERT_PROP(a_done_in_pair, pair_st.done |-> state_q == ST_PAIR, "pair result outside wait state")
  `ASSERT_NEVER(a_no_self_test, (state_q == ST_JST) && (col_q == row_q), "atom tested against itself")
  `ASSERT_PROP(a_own_bit_clear, m_axis_tvalid_o |-> !out_mask_q[out_idx_q], "own bit set in result")
  `ASSERT_PROP(a_count_bound, 1'b1 |-> cnt_q <= CW'(MAX_ATOMS), "atom count beyond capacity")

endmodule

`default_nettype wire

// ===== sv/cnlb_pair_unit.sv =====
// ----------------------------------------------------------------------------
// cnlb_pair_unit
// tests one atom pair: per axis a shared adder forms the difference, the
// periodic correction and the magnitude, one 32x32 multiplier squares it,
// then the exact sum of squares is compared against the squared cutoff
// ----------------------------------------------------------------------------
`default_nettype none

module cnlb_pair_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire cnlb_pkg::coord_t                   coord_i_i,
  input  wire cnlb_pkg::coord_t                   coord_j_i,
  input  wire logic [cnlb_pkg::BOX_W-1:0]         box_i,
  input  wire logic [cnlb_pkg::CUTOFF_W-1:0]      cutoff_i,
  output cnlb_pkg::pair_status_t                  status_o
);

  localparam int unsigned DW   = 35;  // corrected difference, signed
  localparam int unsigned CW2  = 36;  // twice the difference, signed
  localparam int unsigned ACCW = 68;  // three squares of up to 66 bits

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [7:0] {
    P_IDLE    = 8'b0000_0001,
    P_DIFF    = 8'b0000_0010,
    P_WRAP_HI = 8'b0000_0100,
    P_WRAP_LO = 8'b0000_1000,
    P_MAG     = 8'b0001_0000,
    P_MUL     = 8'b0010_0000,
    P_ACC     = 8'b0100_0000,
    P_CMP     = 8'b1000_0000
  } pair_state_e;

  pair_state_e state_q, state_d;
  logic [1:0]  axis_q, axis_d;

  logic [DW-1:0]   d_q, d_d;
  logic [63:0]     prod_q, prod_d;
  logic            hi_q, hi_d;
  logic [ACCW-1:0] acc_q, acc_d;

  logic [cnlb_pkg::COORD_W-1:0] ci, cj;
  logic [DW-1:0]  op_a, op_b, sum;
  logic           op_sub;
  logic [DW-1:0]  box_ext;
  logic [CW2-1:0] twice_d, box_w, neg_box;
  logic           gt_half, lt_neg_half;
  logic [31:0]    mul_a;
  logic [ACCW-1:0] hi_term;

  // axis operand select
  always_comb begin
    unique case (axis_q)
      AXIS_X:  begin ci = coord_i_i.x; cj = coord_j_i.x; end
      AXIS_Y:  begin ci = coord_i_i.y; cj = coord_j_i.y; end
      AXIS_Z:  begin ci = coord_i_i.z; cj = coord_j_i.z; end
      default: begin ci = coord_i_i.x; cj = coord_j_i.x; end
    endcase
  end

  assign box_ext     = {{(DW-cnlb_pkg::BOX_W){1'b0}}, box_i};
  assign twice_d     = {d_q, 1'b0};
  assign box_w       = {{(CW2-cnlb_pkg::BOX_W){1'b0}}, box_i};
  assign neg_box     = {CW2{1'b0}} - box_w;
  assign gt_half     = $signed(twice_d) > $signed(box_w);
  assign lt_neg_half = $signed(twice_d) < $signed(neg_box);

  // shared adder
  always_comb begin
    op_a   = d_q;
    op_b   = {DW{1'b0}};
    op_sub = 1'b0;
    unique case (state_q)
      P_DIFF: begin
        op_a   = {{(DW-cnlb_pkg::COORD_W){cj[cnlb_pkg::COORD_W-1]}}, cj};
        op_b   = {{(DW-cnlb_pkg::COORD_W){ci[cnlb_pkg::COORD_W-1]}}, ci};
        op_sub = 1'b1;
      end
      P_WRAP_HI: begin
        op_b   = box_ext;
        op_sub = 1'b1;
      end
      P_WRAP_LO: begin
        op_b   = box_ext;
      end
      P_MAG: begin
        op_a   = {DW{1'b0}};
        op_b   = d_q;
        op_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = op_a + (op_sub ? ~op_b : op_b) + {{(DW-1){1'b0}}, op_sub};

  assign mul_a   = d_q[31:0];
  assign hi_term = hi_q ? ({3'b000, d_q[31:0], 33'd0} + {4'b0001, 64'd0}) : {ACCW{1'b0}};

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    d_d     = d_q;
    prod_d  = prod_q;
    hi_d    = hi_q;
    acc_d   = acc_q;
    unique case (state_q)
      P_IDLE: begin
        if (start_i) begin
          axis_d  = AXIS_X;
          acc_d   = {ACCW{1'b0}};
          state_d = P_DIFF;
        end
      end
      P_DIFF: begin
        d_d     = sum;
        state_d = P_WRAP_HI;
      end
      P_WRAP_HI: begin
        if (gt_half) d_d = sum;
        state_d = P_WRAP_LO;
      end
      P_WRAP_LO: begin
        if (lt_neg_half) d_d = sum;
        state_d = P_MAG;
      end
      P_MAG: begin
        if (d_q[DW-1]) d_d = sum;
        state_d = P_MUL;
      end
      P_MUL: begin
        // |d| < 2^33: low word squared here, top bit folded in on accumulate
        prod_d  = 64'(mul_a) * 64'(mul_a);
        hi_d    = d_q[32];
        state_d = P_ACC;
      end
      P_ACC: begin
        acc_d = acc_q + {4'b0000, prod_q} + hi_term;
        if (axis_q == AXIS_Z) begin
          state_d = P_CMP;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = P_DIFF;
        end
      end
      P_CMP: begin
        state_d = P_IDLE;
      end
      default: state_d = P_IDLE;
    endcase
  end

  assign status_o.done = (state_q == P_CMP);
  assign status_o.hit  = acc_q < {4'b0000, cutoff_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      axis_q  <= AXIS_X;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    prod_q <= prod_d;
    hi_q   <= hi_d;
    acc_q  <= acc_d;
  end

  `include "assert_macros.svh"

  `ASSERT_PROP(a_start_when_idle, start_i |-> state_q == P_IDLE, "pair start while busy")
  `ASSERT_PROP(a_mag_fits, state_q == P_MUL |-> d_q[DW-1:33] == 2'b00, "magnitude exceeds 33 bits")
  `ASSERT_PROP(a_done_single, status_o.done |=> !status_o.done, "pair done held over two cycles")

endmodule

`default_nettype wire
